@@ rtl/core/ccfr_pkg.sv @@
// Shared constants and types for the checksummed command frame receiver.
// No dependencies; used by the top level and ccfr_frame under rtl/core.
package ccfr_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;

	localparam int NUM_FIELDS = 4;

	// Reset values of the configuration registers
	localparam logic [3:0] REPEATS_RST  = 4'd3;
	localparam logic [7:0] LENGTH_RST   = 8'h09;
	localparam logic [7:0] EXTENDED_RST = 8'h33;

	// Frame positions with a role of their own; 2 to 7 are body bytes
	localparam logic [3:0] POS_HDR_FIRST  = 4'd0;
	localparam logic [3:0] POS_HDR_SECOND = 4'd1;
	localparam logic [3:0] POS_BODY_FIRST = 4'd2;
	localparam logic [3:0] POS_LENGTH     = 4'd3;
	localparam logic [3:0] POS_BODY_LAST  = 4'd7;
	localparam logic [3:0] POS_CHECKSUM   = 4'd8;
	localparam logic [3:0] POS_TEMP_HIGH  = 4'd9;
	localparam logic [3:0] POS_TEMP_LOW   = 4'd10;

	typedef enum logic [1:0] {
		CFG_REPEATS  = 2'd0,
		CFG_LENGTH   = 2'd1,
		CFG_EXTENDED = 2'd2
	} cfg_idx_t;

	// Update request from the frame tracker to the debounce lanes
	typedef struct packed {
		logic                         upd;
		logic [NUM_FIELDS-1:0][7:0]   body;
	} deb_req_t;

endpackage

@@ rtl/core/checksummed_command_frame_receiver_core.sv @@
// Checksummed command frame receiver: top level with channels, config registers and pipeline.
// Depends on ccfr_pkg, ccfr_frame and ccfr_debounce.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one received byte per request.
//   Output channel (out_valid, out_stall, fields) returns exactly one result per byte:
//   frame_valid / temperature_updated pulse flags plus the currently accepted field
//   values and temperature target.
//   Path: an accepted byte is held in the input register, passes the frame and debounce
//   logic, and lands in the result register, from which it can be taken.
//   Throughput: one byte per cycle while out_stall is low or no result is held.
//   While out_stall is high with a result held, the input register stays full and
//   in_stall rises the same cycle; a held result never changes.
//   Config: cfg_we writes cfg_data into register cfg_index (0 required repeats,
//   1 length code, 2 extended command); index 3 is ignored. Write only when idle.
//   Reset (arst_n low) restarts the header hunt, clears debounce state, accepted
//   values and temperature, and restores repeats 3, length 9, extended command 0x33.
module checksummed_command_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_valid,
	output logic [7:0]  fluid_type,
	output logic [7:0]  tank_curve,
	output logic [7:0]  work_command,
	output logic [7:0]  pairing_confirm,
	output logic [15:0] temperature_target,
	output logic        temperature_updated,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [3:0] repeats_q;
	logic [7:0] length_q;
	logic [7:0] extended_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic        out_valid_q;
	logic        frame_valid_q;
	logic        temp_upd_q;
	logic [15:0] temp_q;
	logic [ccfr_pkg::NUM_FIELDS-1:0][7:0] accepted_q;

	ccfr_pkg::deb_req_t deb;
	logic                                 frame_ok;
	logic                                 temp_done;
	logic [15:0]                          temp_next;
	logic [ccfr_pkg::NUM_FIELDS-1:0][7:0] accepted_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeats_q  <= ccfr_pkg::REPEATS_RST;
			length_q   <= ccfr_pkg::LENGTH_RST;
			extended_q <= ccfr_pkg::EXTENDED_RST;
		end else if (cfg_we) begin
			unique case (ccfr_pkg::cfg_idx_t'(cfg_index))
				ccfr_pkg::CFG_REPEATS:  repeats_q  <= cfg_data[3:0];
				ccfr_pkg::CFG_LENGTH:   length_q   <= cfg_data;
				ccfr_pkg::CFG_EXTENDED: extended_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the held byte when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	ccfr_frame u_frame (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.rx_byte          (byte_s1),
		.length_code      (length_q),
		.extended_command (extended_q),
		.cmd_next         (accepted_next[2]),
		.deb              (deb),
		.frame_valid      (frame_ok),
		.temp_done        (temp_done),
		.temp_next        (temp_next)
	);

	for (genvar f = 0; f < ccfr_pkg::NUM_FIELDS; f++) begin : g_lane
		ccfr_debounce u_debounce (
			.clk              (clk),
			.arst_n           (arst_n),
			.upd              (deb.upd),
			.field_byte       (deb.body[f]),
			.required_repeats (repeats_q),
			.accepted_next    (accepted_next[f])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_valid_q <= frame_ok;
			temp_upd_q    <= temp_done;
			temp_q        <= temp_next;
			accepted_q    <= accepted_next;
		end
	end

	assign out_valid           = out_valid_q;
	assign frame_valid         = frame_valid_q;
	assign fluid_type          = accepted_q[0];
	assign tank_curve          = accepted_q[1];
	assign work_command        = accepted_q[2];
	assign pairing_confirm     = accepted_q[3];
	assign temperature_target  = temp_q;
	assign temperature_updated = temp_upd_q;

`ifndef NO_ASSERTIONS
	// A byte cannot both finish a frame and finish the temperature extension
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_valid && temperature_updated))
		else $error("frame_valid and temperature_updated on the same result");

	// Input backpressure only comes from a held, stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && valid_s1))
		else $error("input stalled without a stalled result");

	// A debounce update only happens on a byte that moves into the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		deb.upd |=> (out_valid && frame_valid))
		else $error("debounce update without a valid frame result");
`endif

endmodule

@@ rtl/core/ccfr_debounce.sv @@
// One debounce lane: a field value is accepted after enough identical valid frames.
// No package dependency; the top level instantiates one lane per field.
module ccfr_debounce (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       upd,
	input  logic [7:0] field_byte,
	input  logic [3:0] required_repeats,
	output logic [7:0] accepted_next
);

	logic [7:0] pending_q;
	logic [3:0] count_q;
	logic [7:0] accepted_q;
	logic [7:0] pending_d;
	logic [3:0] count_d;

	always_comb begin
		pending_d     = pending_q;
		count_d       = count_q;
		accepted_next = accepted_q;
		if (upd) begin
			if (count_q == 4'd0) begin
				pending_d = field_byte;
			end
			if (pending_d == field_byte) begin
				if (count_q < required_repeats) begin
					count_d = count_q + 4'd1;
				end
				if (count_d >= required_repeats) begin
					accepted_next = field_byte;
				end
			end else begin
				// a differing byte restarts the run and is not counted
				count_d = 4'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 8'd0;
			count_q    <= 4'd0;
			accepted_q <= 8'd0;
		end else begin
			pending_q  <= pending_d;
			count_q    <= count_d;
			accepted_q <= accepted_next;
		end
	end

endmodule

@@ rtl/core/ccfr_frame.sv @@
// Frame tracker: header hunt, body capture, checksum and length check, temperature bytes.
// Depends on ccfr_pkg for positions, header codes and the debounce request struct.
module ccfr_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  logic [7:0]         length_code,
	input  logic [7:0]         extended_command,
	input  logic [7:0]         cmd_next,
	output ccfr_pkg::deb_req_t deb,
	output logic               frame_valid,
	output logic               temp_done,
	output logic [15:0]        temp_next
);

	logic [3:0]  pos_q;
	logic [3:0]  pos_d;
	logic [7:0]  sum_q;
	logic [7:0]  sum_d;
	logic [7:0]  len_q;
	logic [7:0]  temp_hi_q;
	logic [15:0] temp_q;
	logic [ccfr_pkg::NUM_FIELDS-1:0][7:0] body_q;

	always_comb begin
		pos_d       = pos_q;
		sum_d       = sum_q;
		frame_valid = 1'b0;
		temp_done   = 1'b0;
		unique case (pos_q)
			ccfr_pkg::POS_HDR_FIRST: begin
				sum_d = rx_byte;
				pos_d = (rx_byte == ccfr_pkg::HDR_FIRST) ? ccfr_pkg::POS_HDR_SECOND
				                                         : ccfr_pkg::POS_HDR_FIRST;
			end
			ccfr_pkg::POS_HDR_SECOND: begin
				if (rx_byte == ccfr_pkg::HDR_SECOND) begin
					sum_d = sum_q + rx_byte;
					pos_d = ccfr_pkg::POS_BODY_FIRST;
				end else if (rx_byte == ccfr_pkg::HDR_FIRST) begin
					// repeated first header byte: stay, keep the sum of the first one
					pos_d = ccfr_pkg::POS_HDR_SECOND;
				end else begin
					pos_d = ccfr_pkg::POS_HDR_FIRST;
				end
			end
			4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
				sum_d = sum_q + rx_byte;
				pos_d = pos_q + 4'd1;
			end
			ccfr_pkg::POS_CHECKSUM: begin
				pos_d = ccfr_pkg::POS_HDR_FIRST;
				sum_d = 8'd0;
				if (rx_byte == 8'(8'd0 - sum_q) && len_q == length_code) begin
					frame_valid = 1'b1;
					if (cmd_next == extended_command) begin
						pos_d = ccfr_pkg::POS_TEMP_HIGH;
					end
				end
			end
			ccfr_pkg::POS_TEMP_HIGH: begin
				pos_d = ccfr_pkg::POS_TEMP_LOW;
			end
			ccfr_pkg::POS_TEMP_LOW: begin
				temp_done = 1'b1;
				pos_d     = ccfr_pkg::POS_HDR_FIRST;
				sum_d     = 8'd0;
			end
			default: begin
				pos_d = ccfr_pkg::POS_HDR_FIRST;
				sum_d = 8'd0;
			end
		endcase
	end

	assign deb.upd   = step & frame_valid;
	assign deb.body  = body_q;
	assign temp_next = (step && temp_done) ? {temp_hi_q, rx_byte} : temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= ccfr_pkg::POS_HDR_FIRST;
			sum_q  <= 8'd0;
			temp_q <= 16'd0;
		end else if (step) begin
			pos_q  <= pos_d;
			sum_q  <= sum_d;
			temp_q <= temp_next;
		end
	end

	// Frame bytes: written before they are read within each frame
	always_ff @(posedge clk) begin
		if (step) begin
			if (pos_q == ccfr_pkg::POS_LENGTH) begin
				len_q <= rx_byte;
			end
			if (pos_q > ccfr_pkg::POS_LENGTH && pos_q <= ccfr_pkg::POS_BODY_LAST) begin
				body_q[pos_q[1:0]] <= rx_byte;
			end
			if (pos_q == ccfr_pkg::POS_TEMP_HIGH) begin
				temp_hi_q <= rx_byte;
			end
		end
	end

endmodule
